// ===== src/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the websocket frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int LENGTH_BITS_DEF = 64;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;
  localparam logic [3:0] OPCODE_TEXT = 4'h1;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

endpackage

// ===== src/wsfd_core.sv =====
// ----------------------------------------------------------------------------
// wsfd_core
// Frame parser: header, extended length and masking key decode, payload
// unmasking, with a registered result stage.
// ----------------------------------------------------------------------------
module wsfd_core
  import wsfd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [7:0] s_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_fin,
  output logic [3:0] out_opcode,
  output logic       out_masked,
  output logic       out_empty_frame,
  output logic       out_last
);

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             cnt_r, cnt_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             kidx_r, kidx_nxt;
  logic                   fin_r, fin_nxt;
  logic [3:0]             opc_r, opc_nxt;
  logic                   msk_r, msk_nxt;

  logic                   out_valid_r;
  logic [7:0]             out_data_r;
  logic                   out_fin_r;
  logic [3:0]             out_opc_r;
  logic                   out_msk_r;
  logic                   out_empty_r;
  logic                   out_last_r;

  logic                   emit_nxt;
  logic [7:0]             data_nxt;
  logic                   empty_nxt;
  logic                   last_nxt;

  logic                   adv;
  logic                   step;
  logic [6:0]             len7;
  logic [LENGTH_BITS-1:0] len7_ext;
  logic [LENGTH_BITS-1:0] ext_len;
  logic                   cnt_one;
  logic                   hdr_done;
  logic [LENGTH_BITS-1:0] hdr_len;
  logic                   hdr_empty;
  logic [7:0]             key_byte;

  assign adv     = !out_valid_r || out_ready;
  assign step    = s_valid && adv;
  assign s_ready = adv;

  assign len7     = s_byte[6:0];
  assign len7_ext = LENGTH_BITS'(len7);
  assign ext_len  = {len_r[LENGTH_BITS-9:0], s_byte};
  assign cnt_one  = (cnt_r == 4'd1);

  // header completes on this beat, with this payload length
  always_comb begin
    hdr_done = 1'b0;
    hdr_len  = len_r;
    case (phase_r)
      PH_HDR1: begin
        hdr_done = !s_byte[7] && (len7 != LEN7_EXT16) && (len7 != LEN7_EXT64);
        hdr_len  = len7_ext;
      end
      PH_EXTLEN: begin
        hdr_done = cnt_one && !msk_r;
        hdr_len  = ext_len;
      end
      PH_KEY: begin
        hdr_done = cnt_one;
        hdr_len  = len_r;
      end
      default: begin
        hdr_done = 1'b0;
        hdr_len  = len_r;
      end
    endcase
  end

  assign hdr_empty = hdr_done && (hdr_len == '0);

  always_comb begin
    case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    kidx_nxt  = kidx_r;
    fin_nxt   = fin_r;
    opc_nxt   = opc_r;
    msk_nxt   = msk_r;
    case (phase_r)
      PH_HDR1: begin
        msk_nxt = s_byte[7];
        if (len7 == LEN7_EXT16) begin
          cnt_nxt   = EXT16_BYTES;
          len_nxt   = '0;
          phase_nxt = PH_EXTLEN;
        end else if (len7 == LEN7_EXT64) begin
          cnt_nxt   = EXT64_BYTES;
          len_nxt   = '0;
          phase_nxt = PH_EXTLEN;
        end else if (s_byte[7]) begin
          len_nxt   = len7_ext;
          cnt_nxt   = KEY_BYTES;
          key_nxt   = '0;
          phase_nxt = PH_KEY;
        end else begin
          len_nxt = len7_ext;
        end
      end
      PH_EXTLEN: begin
        len_nxt = ext_len;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_one && msk_r) begin
          cnt_nxt   = KEY_BYTES;
          key_nxt   = '0;
          phase_nxt = PH_KEY;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], s_byte};
        cnt_nxt = cnt_r - 4'd1;
      end
      PH_PAYLOAD: begin
        kidx_nxt = kidx_r + 2'd1;
        len_nxt  = len_r - LENGTH_BITS'(1);
        if (len_r == LENGTH_BITS'(1)) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        fin_nxt   = s_byte[7];
        opc_nxt   = s_byte[3:0];
        phase_nxt = PH_HDR1;
      end
    endcase
    if (hdr_done) begin
      kidx_nxt = '0;
      if (hdr_empty) begin
        len_nxt   = '0;
        phase_nxt = PH_HDR0;
      end else begin
        len_nxt   = hdr_len;
        phase_nxt = PH_PAYLOAD;
      end
    end
  end

  // result
  always_comb begin
    emit_nxt  = 1'b0;
    data_nxt  = 8'd0;
    empty_nxt = 1'b0;
    last_nxt  = 1'b0;
    case (phase_r)
      PH_PAYLOAD: begin
        emit_nxt = 1'b1;
        data_nxt = msk_r ? (s_byte ^ key_byte) : s_byte;
        last_nxt = (len_r == LENGTH_BITS'(1));
      end
      PH_HDR1, PH_EXTLEN, PH_KEY: begin
        emit_nxt  = hdr_empty;
        empty_nxt = hdr_empty;
        last_nxt  = hdr_empty;
      end
      default: begin
        emit_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      cnt_r   <= '0;
      len_r   <= '0;
      key_r   <= '0;
      kidx_r  <= '0;
      fin_r   <= 1'b1;
      opc_r   <= OPCODE_TEXT;
      msk_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      key_r   <= key_nxt;
      kidx_r  <= kidx_nxt;
      fin_r   <= fin_nxt;
      opc_r   <= opc_nxt;
      msk_r   <= msk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step && emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r  <= data_nxt;
      out_fin_r   <= fin_nxt;
      out_opc_r   <= opc_nxt;
      out_msk_r   <= msk_nxt;
      out_empty_r <= empty_nxt;
      out_last_r  <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_byte   = out_data_r;
  assign out_fin         = out_fin_r;
  assign out_opcode      = out_opc_r;
  assign out_masked      = out_msk_r;
  assign out_empty_frame = out_empty_r;
  assign out_last        = out_last_r;

endmodule

// ===== src/websocket_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_decoder_top
// Byte-serial websocket frame deframer with payload unmasking.
// ----------------------------------------------------------------------------
// usage
//   in_ channel: one raw stream byte per beat (in_valid / in_ready)
//   out_ channel: one payload byte per beat, tagged with fin, opcode,
//     masked and last; a zero-length frame gives one beat with
//     empty_frame and last set and data zero
//   header, extended length and key bytes give no output beat but that empty_frame beat
// path: input beat to output beat through the input register, then the
//   parse logic into the output register
// throughput: one byte per cycle while the output is not stalled, limited by the single-step parser
// reset: synchronous, active low; parser waits for the first header byte,
//   fin = 1, opcode = text, both stages empty
// stall: while out_ready is low the output register holds its beat, the
//   input register takes one more byte, then in_ready drops
// ----------------------------------------------------------------------------
module websocket_frame_decoder_top
  import wsfd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_fin,
  output logic [3:0] out_opcode,
  output logic       out_masked,
  output logic       out_empty_frame,
  output logic       out_last
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       core_ready;

  assign in_ready = !in_valid_r || core_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_byte_r <= in_stream_byte;
    end
  end

  wsfd_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .s_valid         (in_valid_r),
    .s_ready         (core_ready),
    .s_byte          (in_byte_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_fin         (out_fin),
    .out_opcode      (out_opcode),
    .out_masked      (out_masked),
    .out_empty_frame (out_empty_frame),
    .out_last        (out_last)
  );

endmodule

// ===== tb/websocket_frame_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder_top_tb
// Streams websocket frames byte by byte into the deframer: a few directed
// zero-length frames in every length form, then random frames of all
// opcodes, mask settings and length forms, ending on a frame whose 64-bit
// length has its top bit set. A frame tracker follows the header state and
// predicts every output beat, which is checked field by field in order.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_top_tb;
  import wsfd_pkg::*;

  localparam int LEN_BITS = LENGTH_BITS_DEF;

  typedef enum int {
    LF_SHORT,
    LF_EXT16,
    LF_EXT64
  } len_form_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       fin;
    logic [3:0] opcode;
    logic       masked;
    logic       empty_frame;
    logic       last;
  } payload_beat_t;

  class frame_scoreboard;
    phase_t          ph;
    logic [3:0]      hdr_left;
    logic [63:0]     frame_len;
    logic [63:0]     left_in_frame;
    logic [31:0]     key;
    logic [1:0]      key_pos;
    logic            cur_fin;
    logic [3:0]      cur_opcode;
    logic            cur_masked;
    logic [63:0]     len_mask;
    payload_beat_t   beat_q[$];
    int              errors;

    function new();
      ph            = PH_HDR0;
      hdr_left      = '0;
      frame_len     = '0;
      left_in_frame = '0;
      key           = '0;
      key_pos       = '0;
      cur_fin       = 1'b1;
      cur_opcode    = OPCODE_TEXT;
      cur_masked    = 1'b0;
      len_mask      = (LEN_BITS >= 64) ? '1 : ((64'd1 << LEN_BITS) - 64'd1);
      errors        = 0;
    endfunction

    function int pending();
      return beat_q.size();
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void add_beat(input logic [7:0] d, input logic empty, input logic lst);
      payload_beat_t b;
      b.data_byte   = d;
      b.fin         = cur_fin;
      b.opcode      = cur_opcode;
      b.masked      = cur_masked;
      b.empty_frame = empty;
      b.last        = lst;
      beat_q.push_back(b);
    endfunction

    function void header_done();
      frame_len = frame_len & len_mask;
      key_pos   = '0;
      if (frame_len == 64'd0) begin
        left_in_frame = '0;
        ph = PH_HDR0;
        add_beat(8'h00, 1'b1, 1'b1);
      end else begin
        left_in_frame = frame_len;
        ph = PH_PAYLOAD;
      end
    endfunction

    function void length_done();
      if (cur_masked) begin
        hdr_left = KEY_BYTES;
        key = '0;
        ph = PH_KEY;
      end else begin
        header_done();
      end
    endfunction

    function void note_byte(input logic [7:0] b);
      logic [7:0] d;
      case (ph)
        PH_HDR1: begin
          cur_masked = b[7];
          frame_len  = '0;
          if (b[6:0] == LEN7_EXT16) begin
            hdr_left = EXT16_BYTES;
            ph = PH_EXTLEN;
          end else if (b[6:0] == LEN7_EXT64) begin
            hdr_left = EXT64_BYTES;
            ph = PH_EXTLEN;
          end else begin
            frame_len = {57'd0, b[6:0]};
            length_done();
          end
        end
        PH_EXTLEN: begin
          frame_len = ((frame_len << 8) | {56'd0, b}) & len_mask;
          hdr_left  = hdr_left - 4'd1;
          if (hdr_left == 4'd0) length_done();
        end
        PH_KEY: begin
          key      = {key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 4'd0) header_done();
        end
        PH_PAYLOAD: begin
          d = b;
          if (cur_masked) d = d ^ 8'(key >> (8 * (3 - key_pos)));
          key_pos       = key_pos + 2'd1;
          left_in_frame = left_in_frame - 64'd1;
          if (left_in_frame == 64'd0) begin
            ph = PH_HDR0;
            add_beat(d, 1'b0, 1'b1);
          end else begin
            add_beat(d, 1'b0, 1'b0);
          end
        end
        default: begin
          cur_fin    = b[7];
          cur_opcode = b[3:0];
          ph = PH_HDR1;
        end
      endcase
    endfunction

    task check_beat(input payload_beat_t got);
      payload_beat_t want;
      if (beat_q.size() == 0) begin
        report($sformatf("output beat with nothing expected: %p", got));
      end else begin
        want = beat_q.pop_front();
        if (got.data_byte !== want.data_byte)
          report($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
        if (got.fin !== want.fin)
          report($sformatf("fin %b, expected %b", got.fin, want.fin));
        if (got.opcode !== want.opcode)
          report($sformatf("opcode %h, expected %h", got.opcode, want.opcode));
        if (got.masked !== want.masked)
          report($sformatf("masked %b, expected %b", got.masked, want.masked));
        if (got.empty_frame !== want.empty_frame)
          report($sformatf("empty_frame %b, expected %b", got.empty_frame, want.empty_frame));
        if (got.last !== want.last)
          report($sformatf("last %b, expected %b", got.last, want.last));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_stream_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_fin;
  logic [3:0] out_opcode;
  logic       out_masked;
  logic       out_empty_frame;
  logic       out_last;

  frame_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int bytes_sent = 0;

  websocket_frame_decoder_top #(
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_fin        (out_fin),
    .out_opcode     (out_opcode),
    .out_masked     (out_masked),
    .out_empty_frame(out_empty_frame),
    .out_last       (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("websocket_frame_decoder_top_tb: FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic fin_b, input logic [3:0] op, input logic mask_b,
                            input len_form_t form, input logic [63:0] len, input int nbytes);
    logic [31:0] k;
    k = $urandom;
    send_byte({fin_b, 3'($urandom_range(0, 7)), op});
    case (form)
      LF_EXT16: begin
        send_byte({mask_b, LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      LF_EXT64: begin
        send_byte({mask_b, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      default: send_byte({mask_b, len[6:0]});
    endcase
    if (mask_b) begin
      for (int i = 3; i >= 0; i--) send_byte(k[8*i +: 8]);
    end
    for (int i = 0; i < nbytes; i++) send_byte(8'($urandom));
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    int w;
    payload_beat_t got;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        w = 400;
        hold_req = 1'b0;
      end else begin
        w = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{out_data_byte, out_fin, out_opcode, out_masked, out_empty_frame, out_last};
      sb.check_beat(got);
    end
  end

  initial begin
    int r;
    int len;
    bit hold_done;
    bit pause_done;
    len_form_t form;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-length frames in every length form
    send_frame(1'b0, 4'h0, 1'b0, LF_SHORT, 64'd0, 0);
    send_frame(1'b1, 4'hf, 1'b1, LF_SHORT, 64'd0, 0);
    send_frame(1'b1, 4'h8, 1'b0, LF_EXT16, 64'd0, 0);
    send_frame(1'b0, 4'h2, 1'b0, LF_EXT64, 64'd0, 0);

    while (bytes_sent < 1200) begin
      if (!hold_done && bytes_sent >= 400) begin
        hold_done = 1'b1;
        idle_on   = 1'b0;
        hold_req  = 1'b1;
      end
      if (!pause_done && bytes_sent >= 800) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      if ($urandom_range(0, 7) == 0) idle_on = ~idle_on;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        form = LF_SHORT;
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 125) : $urandom_range(0, 20);
      end else if (r < 70) begin
        form = LF_EXT16;
        len  = (r < 67) ? $urandom_range(0, 40) : $urandom_range(126, 300);
      end else if (r < 80) begin
        form = LF_EXT64;
        len  = $urandom_range(0, 40);
      end else if (r < 90) begin
        form = LF_SHORT;
        len  = $urandom_range(0, 125);
      end else begin
        form = LF_SHORT;
        len  = 0;
      end
      send_frame(1'($urandom), 4'($urandom), 1'($urandom), form, 64'(len), len);
    end

    // top length bit set: the frame never ends, only its first bytes are sent
    send_frame(1'b1, 4'h2, 1'b1, LF_EXT64, {1'b1, 31'($urandom), 32'($urandom)}, 6);
    in_valid <= 1'b0;

    for (int i = 0; i < 5000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d expected beats never came", sb.pending()));

    if (sb.errors == 0) begin
      $display("websocket_frame_decoder_top_tb: PASS");
    end else begin
      $display("websocket_frame_decoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule
